/* rtl/erseq_pkg.sv */
package erseq_pkg;

  // Pattern geometry
  localparam int MAX_STEPS = 32;
  localparam int LEN_W     = 6;   // pattern_length / hit_count register width
  localparam int ROT_W     = 5;   // rotation register width
  localparam int POS_W     = 5;   // step position width
  localparam int CFG_IDX_W = 2;

  // Remainder unit: numerator is fed MSB first, left-aligned in NUM_W bits
  localparam int NUM_W = 11;
  localparam int CNT_W = 4;

  localparam logic [CNT_W-1:0] NBITS_SHORT = CNT_W'(LEN_W);
  localparam logic [CNT_W-1:0] NBITS_PROD  = CNT_W'(NUM_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_COUNT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION       = 2'd2;

  // Reset values
  localparam logic [LEN_W-1:0] PATTERN_LENGTH_RST = 6'd16;
  localparam logic [LEN_W-1:0] HIT_COUNT_RST      = 6'd4;
  localparam logic [ROT_W-1:0] ROTATION_RST       = 5'd0;

  // Request to the remainder unit
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
    logic [NUM_W-1:0] num;
  } rem_req_t;

  // Response from the remainder unit
  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] rem;
  } rem_rsp_t;

endpackage

/* rtl/euclidean_rhythm_sequencer.sv */
// An item with advance 0 is reported in the cycle after its transfer.
// An item with advance 1 makes four passes through the shared
// one-bit-per-cycle remainder unit (6 + 6 + 6 + 11 bits).
// One item is handled at a time: input is stalled until the result is loaded
// and while it is held by out_stall.
// Reset (rst_n low, synchronous): position 0, hit flag 0, length 16, 4 hits,
// rotation 0; no result pending.
module euclidean_rhythm_sequencer
  import erseq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_advance,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic [POS_W-1:0]     out_step_index
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_ROT,
    ST_BASE,
    ST_PROD
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] pattern_length_r;
  logic [LEN_W-1:0] hit_count_r;
  logic [ROT_W-1:0] rotation_r;

  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] fill_r;
  logic [ROT_W-1:0] rot_r;
  logic [POS_W-1:0] pos_r;
  logic             hit_flag_r;

  logic             out_valid_r;
  logic             out_hit_r;
  logic [POS_W-1:0] out_step_index_r;

  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] fill_eff;
  logic             in_xfer;
  logic             out_xfer;
  logic [LEN_W-1:0] pos_inc;
  logic [LEN_W-1:0] base_sum;
  logic             hit_calc;

  rem_req_t req;
  rem_rsp_t rsp;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= PATTERN_LENGTH_RST;
      hit_count_r      <= HIT_COUNT_RST;
      rotation_r       <= ROTATION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length_r <= cfg_wdata;
        REG_HIT_COUNT:      hit_count_r      <= cfg_wdata;
        REG_ROTATION:       rotation_r       <= cfg_wdata[ROT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp length to 1..MAX_STEPS and fill to the length
  always_comb begin
    if (pattern_length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length_r > LEN_W'(MAX_STEPS)) begin
      len_eff = LEN_W'(MAX_STEPS);
    end else begin
      len_eff = pattern_length_r;
    end
    fill_eff = (hit_count_r > len_eff) ? len_eff : hit_count_r;
  end

  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  assign pos_inc  = {1'b0, pos_r} + LEN_W'(1);
  assign base_sum = {1'b0, pos_r} + len_r - {1'b0, rsp.rem};

  // Step p is a hit when fill > 0 and ((p - rot) * fill) mod len is zero or above len - fill
  assign hit_calc = (fill_r != '0) &&
                    ((rsp.rem == '0) || ({1'b0, rsp.rem} > (len_r - fill_r)));

  // Sequence the shared remainder unit
  always_comb begin
    state_nxt = state_r;
    req.start = 1'b0;
    req.nbits = NBITS_SHORT;
    req.num   = {pos_inc, {(NUM_W-LEN_W){1'b0}}};
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_advance) begin
          req.start = 1'b1;
          state_nxt = ST_POS;
        end
      end
      ST_POS: begin
        req.num = {1'b0, rot_r, {(NUM_W-LEN_W){1'b0}}};
        if (rsp.done) begin
          req.start = 1'b1;
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        req.num = {base_sum, {(NUM_W-LEN_W){1'b0}}};
        if (rsp.done) begin
          req.start = 1'b1;
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: begin
        req.nbits = NBITS_PROD;
        req.num   = NUM_W'(rsp.rem) * NUM_W'(fill_r);
        if (rsp.done) begin
          req.start = 1'b1;
          state_nxt = ST_PROD;
        end
      end
      ST_PROD: begin
        if (rsp.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, step state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      hit_flag_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Load a new result, else drop the one taken by the receiver
      if ((in_xfer && !in_advance) || (state_r == ST_PROD && rsp.done)) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_IDLE && in_xfer) begin
        len_r  <= len_eff;
        fill_r <= fill_eff;
        rot_r  <= rotation_r;
        if (!in_advance) begin
          out_hit_r        <= hit_flag_r;
          out_step_index_r <= pos_r;
        end
      end
      if (state_r == ST_POS && rsp.done) begin
        pos_r <= rsp.rem;
      end
      if (state_r == ST_PROD && rsp.done) begin
        hit_flag_r       <= hit_calc;
        out_hit_r        <= hit_calc;
        out_step_index_r <= pos_r;
      end
    end
  end

  erseq_rem u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .divisor (len_r),
    .rsp     (rsp)
  );

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_step_index = out_step_index_r;

  // No result is pending while a step is being worked out
  a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_valid_r)
    else $error("result pending during step computation");

  // A report-only transfer gives a result on the next cycle
  a_report_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_advance) |=> (out_valid_r && out_step_index_r == $past(pos_r)))
    else $error("report-only transfer not answered");

  // After a step the position lies inside the pattern
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROD && rsp.done) |-> ({1'b0, pos_r} < len_r))
    else $error("step position outside pattern");

endmodule

/* rtl/erseq_rem.sv */
module erseq_rem
  import erseq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  rem_req_t         req,
  input  logic [LEN_W-1:0] divisor,
  output rem_rsp_t         rsp
);

  logic [NUM_W-1:0] num_r;
  logic [CNT_W-1:0] cnt_r;
  logic [POS_W-1:0] rem_r;
  logic             busy_r;
  logic             done_r;

  logic [LEN_W-1:0] trial;
  logic [POS_W-1:0] rem_nxt;

  // Shift in the next numerator bit and subtract the divisor once if it fits
  always_comb begin
    trial = {rem_r, num_r[NUM_W-1]};
    if (trial >= divisor) begin
      rem_nxt = POS_W'(trial - divisor);
    end else begin
      rem_nxt = trial[POS_W-1:0];
    end
  end

  // Restoring remainder, one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

  // A new operation is only launched on an idle unit
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("remainder unit restarted while busy");

  // The delivered remainder lies below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, rem_r} < divisor))
    else $error("remainder not below divisor");

endmodule
